### hw/rtl/rgblab_pkg.sv
// ----------------------------------------------------------------------------
// rgblab_pkg
// Widths, matrix coefficients and fixed-point constants shared by the linear
// RGB to CIE Lab converter and its lightness-function lanes.
// ----------------------------------------------------------------------------
package rgblab_pkg;

    localparam int CHANNEL_BITS_DEF = 16;
    localparam int WIDE_BITS        = 24;
    localparam int COEF_BITS        = 20;
    localparam int PROD_BITS        = COEF_BITS + WIDE_BITS;
    localparam int SUM_BITS         = PROD_BITS + 2;
    localparam int T_BITS           = 26;
    localparam int F_BITS           = 21;

    // Cube root by digit recurrence, three radicand bits per step.
    localparam int CBRT_STEPS    = 21;
    localparam int ROOT_IN_BITS  = 3 * CBRT_STEPS;
    localparam int ROOT_PAD      = ROOT_IN_BITS - 1 - T_BITS;
    localparam int REM_BITS      = 48;
    localparam int SQ_BITS       = 2 * F_BITS;

    // Linear segment: (24389 * t + 27 * 16 * 2^24 + 25056) / 50112.
    localparam int LIN_T_BITS   = 18;
    localparam int LIN_NUM_BITS = 34;
    localparam int LIN_Q_BITS   = 18;
    localparam int LIN_SHIFT    = 40;
    localparam int LIN_RCP_BITS = 25;
    localparam logic [14:0] LIN_SLOPE = 15'd24389;
    localparam logic [LIN_NUM_BITS-1:0] LIN_OFFSET =
        LIN_NUM_BITS'(64'd27 * 64'd16 * 64'd16777216 + 64'd25056);
    localparam logic [15:0] LIN_DIV = 16'd50112;
    localparam logic [LIN_RCP_BITS-1:0] LIN_RECIP =
        LIN_RCP_BITS'(((64'd1 << LIN_SHIFT) + 64'd50111) / 64'd50112);

    localparam logic [T_BITS-1:0] THRESH =
        T_BITS'((64'd886 * 64'd16777216 + 64'd50000) / 64'd100000);

    // Normalised lightness: divide by 1600 as a shift by 6 and then by 25.
    localparam int L_X_BITS     = 22;
    localparam int L_SHIFT      = 27;
    localparam int L_RCP_BITS   = 23;
    localparam logic [L_RCP_BITS-1:0] L_RECIP =
        L_RCP_BITS'(((64'd1 << L_SHIFT) + 64'd24) / 64'd25);

    // Rows X, Y, Z; columns red, green, blue. White point folded in.
    localparam logic [COEF_BITS-1:0] MAT [3][3] = '{
        '{COEF_BITS'((64'd41245 * 64'd1048576 + 64'd47525) / 64'd95050),
          COEF_BITS'((64'd35758 * 64'd1048576 + 64'd47525) / 64'd95050),
          COEF_BITS'((64'd18042 * 64'd1048576 + 64'd47525) / 64'd95050)},
        '{COEF_BITS'((64'd21267 * 64'd1048576 + 64'd50000) / 64'd100000),
          COEF_BITS'((64'd71516 * 64'd1048576 + 64'd50000) / 64'd100000),
          COEF_BITS'((64'd7216 * 64'd1048576 + 64'd50000) / 64'd100000)},
        '{COEF_BITS'((64'd1933 * 64'd1048576 + 64'd54440) / 64'd108880),
          COEF_BITS'((64'd11919 * 64'd1048576 + 64'd54440) / 64'd108880),
          COEF_BITS'((64'd95022 * 64'd1048576 + 64'd54440) / 64'd108880)}
    };

endpackage

### hw/rtl/linear_rgb_to_cielab.sv
// ----------------------------------------------------------------------------
// linear_rgb_to_cielab
// Converts linear RGB pixels to CIE L*a*b* (D65 white) in a deep pipeline.
// ----------------------------------------------------------------------------
// Usage: one pixel word enters on i_valid/o_stall with the three linear
// channels as unsigned fractions of CHANNEL_BITS bits. One Lab word leaves on
// o_valid/i_stall for every pixel, in order. A word moves at a rising edge
// where valid is high and stall is low.
// Throughput is one pixel per clock while the output is not stalled. There
// are 26 register stages: one stage of matrix products, one of sums, 21 cube
// root stages (one root bit each), then scaling, rounding and saturation.
// Each stage advances when it is empty or the next one advances, so a stalled
// receiver holds the output word while bubbles further up still close; the
// input stalls only once every stage holds a word.
// i_cfg_wr_en/i_cfg_wr_data write the normalised-output bit, which should be
// changed only while the pipeline is empty. Synchronous reset empties the
// pipeline and clears the bit to raw Q8.8 output.
// ----------------------------------------------------------------------------
module linear_rgb_to_cielab
    import rgblab_pkg::*;
#(
    parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic [CHANNEL_BITS-1:0] i_red,
    input  logic [CHANNEL_BITS-1:0] i_green,
    input  logic [CHANNEL_BITS-1:0] i_blue,
    input  logic                    i_cfg_wr_en,
    input  logic                    i_cfg_wr_data,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic signed [16:0]      o_lightness,
    output logic signed [16:0]      o_green_red,
    output logic signed [16:0]      o_blue_yellow
);

    localparam int S_PROD   = 0;
    localparam int S_SUM    = 1;
    localparam int S_LANE   = 2;
    localparam int S_NUM    = S_LANE + CBRT_STEPS;
    localparam int S_RND    = S_NUM + 1;
    localparam int S_OUT    = S_RND + 1;
    localparam int N_STAGES = S_OUT + 1;

    logic                 r_valid [N_STAGES];
    logic [N_STAGES-1:0]  en;
    logic                 r_norm;

    logic [WIDE_BITS-1:0] ch [3];
    logic [PROD_BITS-1:0] r_prod [3][3];
    logic [T_BITS-1:0]    r_t [3];
    logic [F_BITS-1:0]    f [3];
    logic signed [31:0]   r_num [3];
    logic signed [19:0]   r_q [3];
    logic [L_X_BITS-1:0]  r_x;
    logic                 r_neg0;
    logic signed [16:0]   r_out [3];

    function automatic logic signed [16:0] sat_raw(input logic signed [19:0] q);
        if (q > 20'sd32767) begin
            return 17'sd32767;
        end else if (q < -20'sd32768) begin
            return -17'sd32768;
        end
        return 17'(q);
    endfunction

    function automatic logic signed [16:0] sat_unit(input logic signed [20:0] v);
        if (v < 21'sd0) begin
            return 17'sd0;
        end else if (v > 21'sd65535) begin
            return 17'sd65535;
        end
        return 17'(v);
    endfunction

    // A stage may load when it is empty or its word moves on.
    always_comb begin
        en[N_STAGES-1] = !r_valid[N_STAGES-1] || !i_stall;
        for (int i = N_STAGES - 2; i >= 0; i--) begin
            en[i] = !r_valid[i] || en[i+1];
        end
    end

    assign o_stall = !en[0];
    assign o_valid = r_valid[N_STAGES-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < N_STAGES; i++) begin
                r_valid[i] <= 1'b0;
            end
            r_norm <= 1'b0;
        end else begin
            if (en[0]) begin
                r_valid[0] <= i_valid;
            end
            for (int i = 1; i < N_STAGES; i++) begin
                if (en[i]) begin
                    r_valid[i] <= r_valid[i-1];
                end
            end
            if (i_cfg_wr_en) begin
                r_norm <= i_cfg_wr_data;
            end
        end
    end

    always_comb begin
        ch[0] = WIDE_BITS'(i_red)   << (WIDE_BITS - CHANNEL_BITS);
        ch[1] = WIDE_BITS'(i_green) << (WIDE_BITS - CHANNEL_BITS);
        ch[2] = WIDE_BITS'(i_blue)  << (WIDE_BITS - CHANNEL_BITS);
    end

    always_ff @(posedge i_clk) begin
        if (en[S_PROD]) begin
            for (int i = 0; i < 3; i++) begin
                for (int k = 0; k < 3; k++) begin
                    r_prod[i][k] <= PROD_BITS'(MAT[i][k]) * PROD_BITS'(ch[k]);
                end
            end
        end
    end

    for (genvar i = 0; i < 3; i++) begin : g_lane
        logic [SUM_BITS-1:0] sum;
        always_comb begin
            sum = SUM_BITS'(r_prod[i][0]) + SUM_BITS'(r_prod[i][1])
                + SUM_BITS'(r_prod[i][2]) + (SUM_BITS'(1) << (COEF_BITS - 1));
        end
        always_ff @(posedge i_clk) begin
            if (en[S_SUM]) begin
                r_t[i] <= sum[COEF_BITS +: T_BITS];
            end
        end

        rgblab_labf u_labf (
            .i_clk (i_clk),
            .i_en  (en[S_LANE +: CBRT_STEPS]),
            .i_t   (r_t[i]),
            .o_f   (f[i])
        );
    end

    always_ff @(posedge i_clk) begin
        if (en[S_NUM]) begin
            r_num[0] <= 32'(f[1]) * 32'sd116 - 32'sd16777216;
            r_num[1] <= (32'(f[0]) - 32'(f[1])) * 32'sd500;
            r_num[2] <= (32'(f[1]) - 32'(f[2])) * 32'sd200;
        end
    end

    // Round half away from zero: work on the magnitude, restore the sign.
    always_ff @(posedge i_clk) begin
        logic [31:0] mag;
        logic [19:0] q;
        if (en[S_RND]) begin
            for (int i = 0; i < 3; i++) begin
                mag = r_num[i][31] ? 32'(-r_num[i]) : 32'(r_num[i]);
                q   = 20'((mag + 32'd2048) >> 12);
                r_q[i] <= r_num[i][31] ? -$signed(q) : $signed(q);
                if (i == 0) begin
                    r_x <= L_X_BITS'((mag + 32'd800) >> 6);
                end
            end
            r_neg0 <= r_num[0][31];
        end
    end

    always_ff @(posedge i_clk) begin
        logic [L_X_BITS+L_RCP_BITS-1:0] lp;
        logic [L_X_BITS-1:0]            lq;
        if (en[S_OUT]) begin
            lp = (L_X_BITS+L_RCP_BITS)'(r_x) * (L_X_BITS+L_RCP_BITS)'(L_RECIP);
            lq = lp[L_SHIFT +: L_X_BITS];
            if (r_norm) begin
                if (r_neg0) begin
                    r_out[0] <= 17'sd0;
                end else begin
                    r_out[0] <= sat_unit($signed({1'b0, 20'(lq)}));
                end
                r_out[1] <= sat_unit(21'(r_q[1]) + 21'sd32768);
                r_out[2] <= sat_unit(21'(r_q[2]) + 21'sd32768);
            end else begin
                for (int i = 0; i < 3; i++) begin
                    r_out[i] <= sat_raw(r_q[i]);
                end
            end
        end
    end

    assign o_lightness   = r_out[0];
    assign o_green_red   = r_out[1];
    assign o_blue_yellow = r_out[2];

`ifndef NO_ASSERTIONS
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("output word valid straight after reset");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled while the output stage can move");

    a_norm_positive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && r_norm) |-> (!o_lightness[16] && !o_green_red[16]
                                 && !o_blue_yellow[16]))
        else $error("negative value in normalised output");
`endif

endmodule

### hw/rtl/rgblab_labf.sv
// ----------------------------------------------------------------------------
// rgblab_labf
// One lane of the Lab companding function: a pipelined cube root, one root
// bit per stage, with the linear segment computed alongside it.
// ----------------------------------------------------------------------------
module rgblab_labf
    import rgblab_pkg::*;
(
    input  logic                  i_clk,
    input  logic [CBRT_STEPS-1:0] i_en,
    input  logic [T_BITS-1:0]     i_t,
    output logic [F_BITS-1:0]     o_f
);

    logic [REM_BITS-1:0]     r_rem [CBRT_STEPS];
    logic [F_BITS-1:0]       r_y   [CBRT_STEPS];
    logic [SQ_BITS-1:0]      r_sq  [CBRT_STEPS];
    logic [T_BITS-1:0]       r_t   [CBRT_STEPS];
    logic                    r_cub [CBRT_STEPS];
    logic [LIN_NUM_BITS-1:0] r_num [0:1];
    logic [LIN_Q_BITS-1:0]   r_lin [1:CBRT_STEPS-1];

    for (genvar k = 0; k < CBRT_STEPS; k++) begin : g_step
        logic [REM_BITS-1:0]     rem_in, rem_sh, d, n_rem;
        logic [F_BITS-1:0]       y_in, n_y;
        logic [SQ_BITS-1:0]      sq_in, n_sq;
        logic [T_BITS-1:0]       t_in;
        logic [ROOT_IN_BITS-1:0] root_in;
        logic                    take;

        if (k == 0) begin : g_first
            assign rem_in = '0;
            assign y_in   = '0;
            assign sq_in  = '0;
            assign t_in   = i_t;
        end else begin : g_next
            assign rem_in = r_rem[k-1];
            assign y_in   = r_y[k-1];
            assign sq_in  = r_sq[k-1];
            assign t_in   = r_t[k-1];
        end

        // The remainder holds radicand prefix minus root cubed; the trial
        // subtrahend is (2y+1)^3 - (2y)^3 = 12y^2 + 6y + 1.
        always_comb begin
            root_in = {1'b0, t_in, {ROOT_PAD{1'b0}}};
            rem_sh  = {rem_in[REM_BITS-4:0], root_in[ROOT_IN_BITS-1-3*k -: 3]};
            d = (REM_BITS'(sq_in) << 3) + (REM_BITS'(sq_in) << 2)
              + (REM_BITS'(y_in) << 2) + (REM_BITS'(y_in) << 1) + REM_BITS'(1);
            take  = (rem_sh >= d);
            n_rem = take ? (rem_sh - d) : rem_sh;
            n_y   = {y_in[F_BITS-2:0], take};
            n_sq  = take ? ((sq_in << 2) + (SQ_BITS'(y_in) << 2) + SQ_BITS'(1))
                         : (sq_in << 2);
        end

        always_ff @(posedge i_clk) begin
            if (i_en[k]) begin
                r_rem[k] <= n_rem;
                r_y[k]   <= n_y;
                r_sq[k]  <= n_sq;
                r_t[k]   <= t_in;
            end
        end

        if (k == 0) begin : g_lin_num
            logic [LIN_T_BITS-1:0] t_lin;
            always_comb begin
                t_lin = (i_t > THRESH) ? LIN_T_BITS'(THRESH) : LIN_T_BITS'(i_t);
            end
            always_ff @(posedge i_clk) begin
                if (i_en[k]) begin
                    r_cub[k] <= (i_t > THRESH);
                    r_num[0] <= LIN_NUM_BITS'(LIN_SLOPE) * LIN_NUM_BITS'(t_lin)
                              + LIN_OFFSET;
                end
            end
        end else if (k == 1) begin : g_lin_est
            logic [LIN_NUM_BITS+LIN_RCP_BITS-1:0] prod;
            always_comb begin
                prod = (LIN_NUM_BITS+LIN_RCP_BITS)'(r_num[0])
                     * (LIN_NUM_BITS+LIN_RCP_BITS)'(LIN_RECIP);
            end
            always_ff @(posedge i_clk) begin
                if (i_en[k]) begin
                    r_cub[k] <= r_cub[k-1];
                    r_num[1] <= r_num[0];
                    r_lin[1] <= prod[LIN_SHIFT +: LIN_Q_BITS];
                end
            end
        end else if (k == 2) begin : g_lin_fix
            // The estimate is exact or one too large.
            logic [LIN_NUM_BITS-1:0] back;
            always_comb begin
                back = LIN_NUM_BITS'(r_lin[1]) * LIN_NUM_BITS'(LIN_DIV);
            end
            always_ff @(posedge i_clk) begin
                if (i_en[k]) begin
                    r_cub[k] <= r_cub[k-1];
                    r_lin[2] <= (r_num[1] < back) ? (r_lin[1] - 1'b1) : r_lin[1];
                end
            end
        end else begin : g_lin_carry
            always_ff @(posedge i_clk) begin
                if (i_en[k]) begin
                    r_cub[k] <= r_cub[k-1];
                    r_lin[k] <= r_lin[k-1];
                end
            end
        end
    end

    assign o_f = r_cub[CBRT_STEPS-1] ? r_y[CBRT_STEPS-1]
                                     : F_BITS'(r_lin[CBRT_STEPS-1]);

endmodule

### sim/linear_rgb_to_cielab_test.sv
// ----------------------------------------------------------------------------
// linear_rgb_to_cielab_test
// Drives linear RGB pixel words into the converter through a queue-fed driver.
// An independent fixed-point predictor computes the expected Lab word for each
// accepted pixel, and a monitor checks the results in order. The run goes
// through both output modes and three idling patterns.
// ----------------------------------------------------------------------------
module linear_rgb_to_cielab_test;
    import rgblab_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
    } t_pixel;

    typedef struct packed {
        logic signed [16:0] lightness;
        logic signed [16:0] green_red;
        logic signed [16:0] blue_yellow;
    } t_lab;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic [15:0]        i_red = '0;
    logic [15:0]        i_green = '0;
    logic [15:0]        i_blue = '0;
    logic               i_cfg_wr_en = 1'b0;
    logic               i_cfg_wr_data = 1'b0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic signed [16:0] o_lightness;
    logic signed [16:0] o_green_red;
    logic signed [16:0] o_blue_yellow;

    t_pixel pending_pixels[$];
    t_lab   expected_lab[$];
    bit     norm_mode = 1'b0;
    int     send_idle_pct = 0;
    int     recv_idle_pct = 0;
    int     mismatches = 0;

    linear_rgb_to_cielab i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_red         (i_red),
        .i_green       (i_green),
        .i_blue        (i_blue),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_lightness   (o_lightness),
        .o_green_red   (o_green_red),
        .o_blue_yellow (o_blue_yellow)
    );

    always #2 i_clk = ~i_clk;

    function automatic longint coef(longint c, longint d);
        return ((c << 20) + d / 2) / d;
    endfunction

    function automatic longint div_round(longint v, longint d);
        longint mag;
        mag = (v < 0) ? -v : v;
        mag = (mag + d / 2) / d;
        return (v < 0) ? -mag : mag;
    endfunction

    function automatic longint clamp(longint v, longint lo, longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // Lightness function in Q0.20: cube root above the threshold, else the
    // corrected linear segment.
    function automatic longint lightness_fn(longint t);
        longint unsigned n, root, c;
        if (t > (886 * 64'd16777216 + 50000) / 100000) begin
            n = longint'(t) << 36;
            root = 0;
            for (int b = 20; b >= 0; b--) begin
                c = root | (64'd1 << b);
                if (c * c * c <= n) root = c;
            end
            return longint'(root);
        end
        return (24389 * t + 27 * 16 * 64'd16777216 + 25056) / 50112;
    endfunction

    function automatic t_lab pixel_to_lab(t_pixel px, bit norm);
        longint m[3][3];
        longint ch[3], f[3], num[3], res[3];
        longint acc;
        t_lab lab;
        m = '{'{coef(41245, 95050), coef(35758, 95050), coef(18042, 95050)},
              '{coef(21267, 100000), coef(71516, 100000), coef(7216, 100000)},
              '{coef(1933, 108880), coef(11919, 108880), coef(95022, 108880)}};
        ch[0] = longint'(px.red) << 8;
        ch[1] = longint'(px.green) << 8;
        ch[2] = longint'(px.blue) << 8;
        for (int i = 0; i < 3; i++) begin
            acc = 0;
            for (int k = 0; k < 3; k++) acc += m[i][k] * ch[k];
            f[i] = lightness_fn((acc + (64'd1 << 19)) >>> 20);
        end
        num[0] = 116 * f[1] - (64'd16 << 20);
        num[1] = 500 * (f[0] - f[1]);
        num[2] = 200 * (f[1] - f[2]);
        if (norm) begin
            res[0] = clamp(div_round(num[0], 1600), 0, 65535);
            res[1] = clamp(div_round(num[1], 4096) + 32768, 0, 65535);
            res[2] = clamp(div_round(num[2], 4096) + 32768, 0, 65535);
        end else begin
            for (int i = 0; i < 3; i++)
                res[i] = clamp(div_round(num[i], 4096), -32768, 32767);
        end
        lab.lightness   = res[0][16:0];
        lab.green_red   = res[1][16:0];
        lab.blue_yellow = res[2][16:0];
        return lab;
    endfunction

    task automatic report_mismatch(string what, logic [16:0] got, logic [16:0] want);
        $display("MISMATCH %s: got %0d expected %0d at %0t",
                 what, $signed(got), $signed(want), $realtime);
        mismatches++;
    endtask

    // Driver: a word is held until taken, then the next one is offered.
    always @(posedge i_clk) begin
        t_pixel px;
        bit     free;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            free = !i_valid;
            if (i_valid && !o_stall) begin
                expected_lab.push_back(pixel_to_lab({i_red, i_green, i_blue}, norm_mode));
                free = 1'b1;
            end
            if (free) begin
                if (pending_pixels.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    px = pending_pixels.pop_front();
                    i_red   <= px.red;
                    i_green <= px.green;
                    i_blue  <= px.blue;
                    i_valid <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor
    always @(posedge i_clk) begin
        t_lab want;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (expected_lab.size() == 0) begin
                    report_mismatch("unexpected word", o_lightness, '0);
                end else begin
                    want = expected_lab.pop_front();
                    if (o_lightness !== want.lightness)
                        report_mismatch("lightness", o_lightness, want.lightness);
                    if (o_green_red !== want.green_red)
                        report_mismatch("green_red", o_green_red, want.green_red);
                    if (o_blue_yellow !== want.blue_yellow)
                        report_mismatch("blue_yellow", o_blue_yellow, want.blue_yellow);
                end
            end
            i_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    task automatic queue_pixel(int r, int g, int b);
        pending_pixels.push_back('{red: r[15:0], green: g[15:0], blue: b[15:0]});
    endtask

    task automatic wait_drained();
        while (pending_pixels.size() != 0 || expected_lab.size() != 0 || i_valid)
            @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    initial begin
        int send_pct[4] = '{8, 62, 0, 0};
        int recv_pct[4] = '{62, 8, 0, 0};
        int sel;
        int v;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (int ph = 0; ph < 4; ph++) begin
            @(posedge i_clk);
            i_cfg_wr_en   <= 1'b1;
            i_cfg_wr_data <= ph[0];
            @(posedge i_clk);
            i_cfg_wr_en <= 1'b0;
            norm_mode = ph[0];
            send_idle_pct = send_pct[ph];
            recv_idle_pct = recv_pct[ph];
            // Black, white, primaries, secondaries, and values either side of
            // the point where the cube root takes over from the linear segment.
            queue_pixel(0, 0, 0);
            queue_pixel(65535, 65535, 65535);
            queue_pixel(65535, 0, 0);
            queue_pixel(0, 65535, 0);
            queue_pixel(0, 0, 65535);
            queue_pixel(65535, 0, 65535);
            queue_pixel(0, 65535, 65535);
            queue_pixel(65535, 65535, 0);
            queue_pixel(580, 580, 580);
            queue_pixel(581, 581, 581);
            queue_pixel(1, 1, 1);
            queue_pixel(32768, 32768, 32768);
            queue_pixel(21845, 43690, 21845);
            for (int n = 0; n < 100; n++) begin
                sel = $urandom_range(3);
                if (sel == 0) begin
                    queue_pixel($urandom_range(1200), $urandom_range(1200),
                                $urandom_range(1200));
                end else if (sel == 1) begin
                    v = $urandom_range(65535);
                    queue_pixel(v ^ $urandom_range(255), v, v ^ $urandom_range(255));
                end else begin
                    queue_pixel($urandom_range(65535), $urandom_range(65535),
                                $urandom_range(65535));
                end
            end
            wait_drained();
        end
        if (mismatches == 0)
            $display("linear_rgb_to_cielab test passed");
        else
            $display("linear_rgb_to_cielab test failed");
        $finish;
    end

    initial begin
        #400us;
        $display("linear_rgb_to_cielab test failed");
        $finish;
    end

endmodule
